/* rtl/core/lpmc_pkg.sv */
// Shared types, codes and reset constants for the LED pattern mode controller.
`default_nettype none

package lpmc_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned LED_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [LEVEL_W-1:0] FADE_STEP_RST      = 16'd500;
  localparam logic [DELAY_W-1:0] DELAY_FORWARD_RST  = 16'd500;
  localparam logic [DELAY_W-1:0] DELAY_BLINK_RST    = 16'd300;
  localparam logic [DELAY_W-1:0] DELAY_BACKWARD_RST = 16'd100;
  localparam logic [DELAY_W-1:0] DELAY_FADE_RST     = 16'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_STEP      = 3'd0,
    REG_DELAY_FORWARD  = 3'd1,
    REG_DELAY_BLINK    = 3'd2,
    REG_DELAY_BACKWARD = 3'd3,
    REG_DELAY_FADE     = 3'd4
  } reg_idx_t;

  // Operating modes, coded as reported on the result
  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_BLINK    = 2'd1,
    MODE_BACKWARD = 2'd2,
    MODE_FADE     = 2'd3
  } mode_t;

  // Button events
  typedef enum logic [1:0] {
    EVT_BUTTON1 = 2'd0,
    EVT_BUTTON2 = 2'd1,
    EVT_BUTTON3 = 2'd2,
    EVT_NONE    = 2'd3
  } event_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] fade_step;
    logic [DELAY_W-1:0] delay_forward;
    logic [DELAY_W-1:0] delay_blink;
    logic [DELAY_W-1:0] delay_backward;
    logic [DELAY_W-1:0] delay_fade;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [1:0]         forward_index;
    logic               blink_phase;
    logic [1:0]         backward_index;
    logic [LEVEL_W-1:0] fade_level;
    logic               fade_down;
    logic [LED_W-1:0]   led_drive;
    logic [LEVEL_W-1:0] pwm_level;
    logic               pwm_enable;
  } state_t;

  localparam state_t STATE_RST = '{
    mode:           MODE_FORWARD,
    forward_index:  2'd0,
    blink_phase:    1'b0,
    backward_index: 2'd3,
    fade_level:     '0,
    fade_down:      1'b0,
    led_drive:      '0,
    pwm_level:      '0,
    pwm_enable:     1'b0
  };

  typedef struct packed {
    logic [DELAY_W-1:0] next_delay_ms;
    mode_t              current_mode;
    logic [LEVEL_W-1:0] pwm_duty;
    logic               pwm_on;
    logic [LED_W-1:0]   led_bits;
  } result_t;

  // Fixed mode transition table
  function automatic mode_t next_mode(input mode_t cur, input event_t evt);
    mode_t nm;
    nm = cur;
    unique case (cur)
      MODE_FORWARD: begin
        unique case (evt)
          EVT_BUTTON1: nm = MODE_BACKWARD;
          EVT_BUTTON2: nm = MODE_BLINK;
          EVT_BUTTON3: nm = MODE_FADE;
          default:     nm = cur;
        endcase
      end
      MODE_BLINK: begin
        unique case (evt)
          EVT_BUTTON1: nm = MODE_FORWARD;
          EVT_BUTTON2: nm = MODE_BACKWARD;
          EVT_BUTTON3: nm = MODE_FADE;
          default:     nm = cur;
        endcase
      end
      MODE_BACKWARD: begin
        unique case (evt)
          EVT_BUTTON1: nm = MODE_BLINK;
          EVT_BUTTON2: nm = MODE_FORWARD;
          EVT_BUTTON3: nm = MODE_FADE;
          default:     nm = cur;
        endcase
      end
      default: begin
        unique case (evt)
          EVT_NONE: nm = cur;
          default:  nm = MODE_FORWARD;
        endcase
      end
    endcase
    return nm;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lpmc_step.sv */
// One loop step: pattern advance, mode transition and result fields.
`default_nettype none

module lpmc_step (
  input  lpmc_pkg::state_t  cur,
  input  lpmc_pkg::cfg_t    cfg,
  input  logic [1:0]        button_event,
  output lpmc_pkg::state_t  nxt,
  output lpmc_pkg::result_t res
);
  import lpmc_pkg::*;

  state_t             pat;
  logic signed [17:0] lvl;
  logic [DELAY_W-1:0] delay;
  mode_t              target;
  event_t             evt;

  assign evt = event_t'(button_event);

  // Pattern step of the current mode
  always_comb begin
    pat = cur;
    lvl = '0;
    unique case (cur.mode)
      MODE_FORWARD: begin
        pat.led_drive     = LED_W'(1) << cur.forward_index;
        pat.forward_index = cur.forward_index + 2'd1;
      end
      MODE_BLINK: begin
        pat.led_drive   = cur.blink_phase ? '0 : '1;
        pat.blink_phase = ~cur.blink_phase;
      end
      MODE_BACKWARD: begin
        pat.led_drive      = LED_W'(1) << cur.backward_index;
        pat.backward_index = cur.backward_index - 2'd1;
      end
      default: begin
        // add or subtract the step, clamp at both rails
        if (cur.fade_down) begin
          lvl = $signed({2'b00, cur.fade_level}) - $signed({2'b00, cfg.fade_step});
        end else begin
          lvl = $signed({2'b00, cur.fade_level}) + $signed({2'b00, cfg.fade_step});
        end
        if (lvl >= $signed({2'b00, LEVEL_MAX})) begin
          lvl           = $signed({2'b00, LEVEL_MAX});
          pat.fade_down = 1'b1;
        end
        if (lvl <= 18'sd0) begin
          lvl           = 18'sd0;
          pat.fade_down = 1'b0;
        end
        pat.fade_level = lvl[LEVEL_W-1:0];
        pat.pwm_level  = lvl[LEVEL_W-1:0];
      end
    endcase
  end

  // Delay of the mode that ran the pattern
  always_comb begin
    unique case (cur.mode)
      MODE_FORWARD:  delay = cfg.delay_forward;
      MODE_BLINK:    delay = cfg.delay_blink;
      MODE_BACKWARD: delay = cfg.delay_backward;
      default:       delay = cfg.delay_fade;
    endcase
  end

  assign target = next_mode(cur.mode, evt);

  // Mode change: LEDs off, PWM follows fade mode
  always_comb begin
    nxt = pat;
    if (target != cur.mode) begin
      nxt.led_drive  = '0;
      nxt.mode       = target;
      nxt.pwm_enable = (target == MODE_FADE);
      if (target == MODE_FADE) begin
        nxt.pwm_level = '0;
      end
    end
  end

  assign res.led_bits      = nxt.led_drive;
  assign res.pwm_on        = nxt.pwm_enable;
  assign res.pwm_duty      = nxt.pwm_level;
  assign res.current_mode  = nxt.mode;
  assign res.next_delay_ms = delay;

endmodule

`default_nettype wire

/* rtl/core/led_pattern_mode_controller.sv */
// Top level of the LED pattern mode controller: state, config and result register.
//
//  channel | dir | handshake                  | payload
//  s_*     | in  | s_tvalid / s_tready        | s_tdata[1:0] button_event
//  m_*     | out | m_tvalid / m_tready        | m_tdata led, pwm, mode, delay
//  cfg_*   | in  | cfg_wen (no wait)          | cfg_index, cfg_data
//
// One item per clock: the step logic runs between the state registers and the
// result register, so an item is taken every cycle while the result is drained.
// m_tvalid rises in the cycle after an accept. s_tready is low only while a
// result is held and m_tready is low. Synchronous reset restores all state
// and register defaults; no clearing pass.
`default_nettype none

module led_pattern_mode_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] button_event, [7:2] zero
  input  logic [lpmc_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [3:0] led_bits, [4] pwm_on, [20:5] pwm_duty, [22:21] current_mode,
  // [38:23] next_delay_ms, [39] zero
  output logic [lpmc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_wen,
  input  logic [lpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpmc_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import lpmc_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t res;
  logic    accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_step      <= FADE_STEP_RST;
      cfg.delay_forward  <= DELAY_FORWARD_RST;
      cfg.delay_blink    <= DELAY_BLINK_RST;
      cfg.delay_backward <= DELAY_BACKWARD_RST;
      cfg.delay_fade     <= DELAY_FADE_RST;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FADE_STEP:      cfg.fade_step      <= cfg_data;
        REG_DELAY_FORWARD:  cfg.delay_forward  <= cfg_data;
        REG_DELAY_BLINK:    cfg.delay_blink    <= cfg_data;
        REG_DELAY_BACKWARD: cfg.delay_backward <= cfg_data;
        REG_DELAY_FADE:     cfg.delay_fade     <= cfg_data;
        default:            ;
      endcase
    end
  end

  lpmc_step u_step (
    .cur          (state),
    .cfg          (cfg),
    .button_event (s_tdata[1:0]),
    .nxt          (state_next),
    .res          (res_next)
  );

  // State advances on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RST;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {1'b0, res.next_delay_ms, res.current_mode, res.pwm_duty,
                    res.pwm_on, res.led_bits};

`ifndef SYNTHESIS
  // an accepted item always yields a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

  // PWM runs exactly while in fade mode
  a_pwm_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.pwm_on == (res.current_mode == MODE_FADE)))
    else $error("pwm_on disagrees with current mode");

  // state only moves on an accepted item
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state))
    else $error("state changed without an accepted item");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the LED pattern mode controller.
module tb_top;
  import lpmc_pkg::*;

  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 235;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned IDLE_PCT        = 13;
  localparam int unsigned DIR_ROWS        = 24;

  // Mode transition map, two bits per entry, indexed by {mode, event}
  localparam logic [31:0] MODE_MAP = {
    MODE_FADE,     MODE_FORWARD, MODE_FORWARD,  MODE_FORWARD,   // from fade
    MODE_BACKWARD, MODE_FADE,    MODE_FORWARD,  MODE_BLINK,     // from backward
    MODE_BLINK,    MODE_FADE,    MODE_BACKWARD, MODE_FORWARD,   // from blink
    MODE_FORWARD,  MODE_FADE,    MODE_BLINK,    MODE_BACKWARD   // from forward
  };

  typedef struct packed {
    event_t  evt;
    logic    typed;
    result_t want;
  } step_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [IN_TDATA_W-1:0]       s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]      m_tdata;
  logic                        cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DAT_W-1:0]        cfg_data = '0;

  // Predictor copy of configuration and controller state
  logic [LEVEL_W-1:0] fade_amt = FADE_STEP_RST;
  logic [DELAY_W-1:0] step_delay [4];
  mode_t              ctl_mode = MODE_FORWARD;
  logic [1:0]         fwd_idx = 2'd0;
  logic [1:0]         bwd_idx = 2'd3;
  logic               blink_dark = 1'b0;
  logic [LEVEL_W-1:0] fade_lvl = '0;
  logic               fade_falling = 1'b0;
  logic [LED_W-1:0]   led_out = '0;
  logic [LEVEL_W-1:0] pwm_lvl = '0;
  logic               pwm_en = 1'b0;

  result_t     pending_status [$];
  step_row_t   dir_rows [DIR_ROWS];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  bit          steady_run = 1'b0;

  led_pattern_mode_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One loop step: pattern advance, then the button transition
  function automatic result_t step_controller(input event_t evt);
    result_t r;
    int      lvl;
    mode_t   dest;
    case (ctl_mode)
      MODE_FORWARD: begin
        led_out = 4'b0001 << fwd_idx;
        fwd_idx = fwd_idx + 2'd1;
      end
      MODE_BLINK: begin
        led_out = blink_dark ? 4'h0 : 4'hF;
        blink_dark = !blink_dark;
      end
      MODE_BACKWARD: begin
        led_out = 4'b0001 << bwd_idx;
        bwd_idx = bwd_idx - 2'd1;
      end
      default: begin
        lvl = fade_falling ? int'(fade_lvl) - int'(fade_amt) : int'(fade_lvl) + int'(fade_amt);
        if (lvl >= int'(LEVEL_MAX)) begin
          lvl = int'(LEVEL_MAX);
          fade_falling = 1'b1;
        end
        if (lvl <= 0) begin
          lvl = 0;
          fade_falling = 1'b0;
        end
        fade_lvl = lvl[LEVEL_W-1:0];
        pwm_lvl = fade_lvl;
      end
    endcase
    // delay belongs to the mode that ran the pattern
    r.next_delay_ms = step_delay[ctl_mode];
    if (evt != EVT_NONE) begin
      dest = mode_t'(MODE_MAP[2*{ctl_mode, evt} +: 2]);
      if (dest != ctl_mode) begin
        if (ctl_mode == MODE_FADE) pwm_en = 1'b0;
        led_out = '0;
        ctl_mode = dest;
        if (dest == MODE_FADE) begin
          pwm_en = 1'b1;
          pwm_lvl = '0;
        end
      end
    end
    r.led_bits = led_out;
    r.pwm_on = pwm_en;
    r.pwm_duty = pwm_lvl;
    r.current_mode = ctl_mode;
    return r;
  endfunction

  // Register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FADE_STEP:      fade_amt = val;
      REG_DELAY_FORWARD:  step_delay[MODE_FORWARD] = val;
      REG_DELAY_BLINK:    step_delay[MODE_BLINK] = val;
      REG_DELAY_BACKWARD: step_delay[MODE_BACKWARD] = val;
      REG_DELAY_FADE:     step_delay[MODE_FADE] = val;
      default: ;
    endcase
  endtask

  // Offer one item, wait for accept, queue the expected status
  task automatic send_step(input event_t evt, input logic typed, input result_t want);
    result_t exp;
    s_tdata <= {{(IN_TDATA_W-2){1'b0}}, evt};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp = step_controller(evt);
    pending_status.push_back(typed ? want : exp);
    if (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    $display("%0t mismatch %s: expected %h, got %h", $time, field, want, seen);
    mismatch_count++;
  endtask

  // Sink side backpressure
  always @(posedge clk) begin
    m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Result checker
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_status.size() == 0) begin
        $display("%0t unexpected item: expected none, got %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        if (seen.led_bits !== want.led_bits)
          flag_mismatch("led_bits", 32'(want.led_bits), 32'(seen.led_bits));
        if (seen.pwm_on !== want.pwm_on)
          flag_mismatch("pwm_on", 32'(want.pwm_on), 32'(seen.pwm_on));
        if (seen.pwm_duty !== want.pwm_duty)
          flag_mismatch("pwm_duty", 32'(want.pwm_duty), 32'(seen.pwm_duty));
        if (seen.current_mode !== want.current_mode)
          flag_mismatch("current_mode", 32'(want.current_mode), 32'(seen.current_mode));
        if (seen.next_delay_ms !== want.next_delay_ms)
          flag_mismatch("next_delay_ms", 32'(want.next_delay_ms), 32'(seen.next_delay_ms));
        if (m_tdata[OUT_TDATA_W-1] !== 1'b0)
          flag_mismatch("pad", 32'd0, 32'(m_tdata[OUT_TDATA_W-1]));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t timeout, %0d items outstanding", $time, pending_status.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned btn_pct;
    event_t      evt;
    logic [15:0] val;

    step_delay[MODE_FORWARD]  = DELAY_FORWARD_RST;
    step_delay[MODE_BLINK]    = DELAY_BLINK_RST;
    step_delay[MODE_BACKWARD] = DELAY_BACKWARD_RST;
    step_delay[MODE_FADE]     = DELAY_FADE_RST;

    // Directed walk from reset over every transition of the map
    dir_rows = '{
      '{EVT_NONE,    1'b1, '{DELAY_FORWARD_RST, MODE_FORWARD, 16'd0, 1'b0, 4'b0001}},
      '{EVT_NONE,    1'b1, '{DELAY_FORWARD_RST, MODE_FORWARD, 16'd0, 1'b0, 4'b0010}},
      '{EVT_BUTTON2, 1'b1, '{DELAY_FORWARD_RST, MODE_BLINK,   16'd0, 1'b0, 4'b0000}},
      '{EVT_NONE,    1'b0, '0},   // blink on
      '{EVT_BUTTON1, 1'b0, '0},   // blink -> forward
      '{EVT_BUTTON1, 1'b0, '0},   // forward -> backward
      '{EVT_NONE,    1'b0, '0},
      '{EVT_BUTTON1, 1'b0, '0},   // backward -> blink
      '{EVT_BUTTON2, 1'b0, '0},   // blink -> backward
      '{EVT_BUTTON2, 1'b0, '0},   // backward -> forward
      '{EVT_BUTTON3, 1'b0, '0},   // forward -> fade, level to zero
      '{EVT_NONE,    1'b0, '0},
      '{EVT_NONE,    1'b0, '0},
      '{EVT_BUTTON1, 1'b0, '0},   // fade -> forward, pwm off
      '{EVT_NONE,    1'b0, '0},
      '{EVT_BUTTON2, 1'b0, '0},   // forward -> blink
      '{EVT_BUTTON3, 1'b0, '0},   // blink -> fade
      '{EVT_NONE,    1'b0, '0},   // fade keeps its old level counter
      '{EVT_BUTTON2, 1'b0, '0},   // fade -> forward
      '{EVT_BUTTON1, 1'b0, '0},   // forward -> backward
      '{EVT_BUTTON3, 1'b0, '0},   // backward -> fade
      '{EVT_NONE,    1'b0, '0},
      '{EVT_BUTTON3, 1'b0, '0},   // fade -> forward
      '{EVT_NONE,    1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_step(dir_rows[i].evt, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      s_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      for (int r = REG_FADE_STEP; r <= REG_DELAY_FADE; r++) begin
        case (ph)
          0: val = 16'hFFFF;
          1: val = 16'h0000;
          2: val = 16'h0001;
          default: begin
            if (r == REG_FADE_STEP) begin
              case ($urandom_range(0, 3))
                0: val = 16'($urandom_range(20000, 65535));
                1: val = 16'($urandom_range(1, 3000));
                2: val = 16'h0000;
                default: val = 16'($urandom);
              endcase
            end else begin
              val = 16'($urandom);
            end
          end
        endcase
        write_reg(r[CFG_IDX_W-1:0], val);
      end
      // writes past the last register must not land anywhere
      write_reg(CFG_IDX_W'($urandom_range(REG_DELAY_FADE + 1, 2**CFG_IDX_W - 1)),
                CFG_DAT_W'($urandom));
      cfg_wen <= 1'b0;
      steady_run = (ph == 3);
      case ($urandom_range(0, 2))
        0: btn_pct = 3;
        1: btn_pct = 25;
        default: btn_pct = 60;
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < btn_pct)
          evt = event_t'($urandom_range(EVT_BUTTON1, EVT_BUTTON3));
        else
          evt = EVT_NONE;
        send_step(evt, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lpmc_pkg.sv
rtl/core/lpmc_step.sv
rtl/core/led_pattern_mode_controller.sv
test/tb_top.sv
